>>> hdl/ptw_pkg.sv
`default_nettype none
package ptw_pkg;

  typedef enum logic [1:0] {
    REQ_MAP    = 2'd0,
    REQ_UNMAP  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_RSVD   = 2'd3
  } req_code_t;

  localparam logic [63:0] FLAG_PRESENT = 64'h1;
  localparam logic [63:0] FLAG_RW      = 64'h2;
  localparam logic [63:0] FLAG_USER    = 64'h4;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic init_clr;
    logic dir_clr;
    logic pg_clr;
    logic ptr_make;
    logic dir_make;
    logic pg_write;
    logic load_lookup;
    logic set_oor;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_done;
    logic dclr_done;
    logic pclr_done;
    logic reserved;
    logic oor;
    logic lookup;
    logic pae;
    logic ptr_missing;
    logic dir_missing;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/ptw_req_if.sv
`default_nettype none
interface ptw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] virt_addr;
  logic [51:0] phys_addr;
  logic        kernel_page;
  logic        writeable;
  logic [31:0] spare_dir_frame;
  logic [31:0] spare_table_frame;

  modport source (output valid, req_type, virt_addr, phys_addr, kernel_page, writeable,
                  spare_dir_frame, spare_table_frame, input ready);
  modport sink (input valid, req_type, virt_addr, phys_addr, kernel_page, writeable,
                spare_dir_frame, spare_table_frame, output ready);
endinterface
`default_nettype wire

>>> hdl/ptw_rsp_if.sv
`default_nettype none
interface ptw_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] phys_frame;
  logic        used_dir_frame;
  logic        used_table_frame;
  logic        out_of_range;

  modport source (output valid, found, phys_frame, used_dir_frame, used_table_frame,
                  out_of_range, input ready);
  modport sink (input valid, found, phys_frame, used_dir_frame, used_table_frame,
                out_of_range, output ready);
endinterface
`default_nettype wire

>>> hdl/ptw_ctrl.sv
`default_nettype none
module ptw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ptw_pkg::sts_t sts,
  output ptw_pkg::cmd_t cmd
);
  import ptw_pkg::*;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LOOK  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_DCLR  = 9'b000010000,
    S_DMAKE = 9'b000100000,
    S_PCLR  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init_clr = 1'b1;
        if (sts.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.reserved) begin
          state_next = S_OUT;
        end else if (sts.oor) begin
          cmd.set_oor = 1'b1;
          state_next = S_OUT;
        end else if (sts.lookup) begin
          cmd.load_lookup = 1'b1;
          state_next = S_OUT;
        end else if (sts.pae && sts.ptr_missing) begin
          cmd.ptr_make = 1'b1;
          state_next = S_DCLR;
        end else if (sts.dir_missing) begin
          state_next = S_DMAKE;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DCLR: begin
        cmd.dir_clr = 1'b1;
        if (sts.dclr_done) state_next = S_DMAKE;
      end
      S_DMAKE: begin
        cmd.dir_make = 1'b1;
        state_next = S_PCLR;
      end
      S_PCLR: begin
        cmd.pg_clr = 1'b1;
        if (sts.pclr_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.pg_write = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/ptw_dp.sv
`default_nettype none
module ptw_dp #(
  parameter int REGION_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  logic [1:0]    in_req_type,
  input  logic [31:0]   in_virt_addr,
  input  logic [51:0]   in_phys_addr,
  input  logic          in_kernel_page,
  input  logic          in_writeable,
  input  logic [31:0]   in_spare_dir_frame,
  input  logic [31:0]   in_spare_table_frame,
  input  ptw_pkg::cmd_t cmd,
  output ptw_pkg::sts_t sts,
  output logic          found,
  output logic [63:0]   phys_frame,
  output logic          used_dir_frame,
  output logic          used_table_frame,
  output logic          out_of_range
);
  import ptw_pkg::*;

  localparam int DIR_DEPTH  = 2 * REGION_COUNT;
  localparam int PAGE_DEPTH = REGION_COUNT * 1024;
  localparam int DW = $clog2(DIR_DEPTH);
  localparam int PW = $clog2(PAGE_DEPTH);

  logic pae_mode;
  logic [1:0]  req_type;
  logic [31:0] virt;
  logic [51:0] phys;
  logic        kernel, wr;
  logic [31:0] dir_frame, tab_frame;

  logic [63:0] ptr_tab [4];
  logic [63:0] dir_mem [DIR_DEPTH];
  logic [63:0] pg_mem  [PAGE_DEPTH];
  logic [63:0] dir_q, pg_q;

  logic [PW-1:0] clear_counter, clear_counter_next;

  logic [1:0]    d;
  logic [10:0]   tidx_w;
  logic [DW-1:0] tidx;
  logic [PW-1:0] slot, pmask;
  logic [10:0]   dclr_w;
  logic [63:0]   pg_val;
  logic          hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pae_mode <= 1'b0;
    end else if (cfg_we) begin
      pae_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type  <= in_req_type;
      virt      <= in_virt_addr;
      phys      <= in_phys_addr;
      kernel    <= in_kernel_page;
      wr        <= in_writeable;
      dir_frame <= in_spare_dir_frame;
      tab_frame <= in_spare_table_frame;
    end
  end

  assign d      = virt[31:30];
  assign tidx_w = pae_mode ? virt[31:21] : {1'b0, virt[31:22]};
  assign tidx   = tidx_w[DW-1:0];
  assign slot   = virt[12 +: PW];
  assign pmask  = pae_mode ? PW'(511) : PW'(1023);
  assign dclr_w = {d, clear_counter[8:0]};

  assign pg_val = ({12'b0, phys} | FLAG_PRESENT | (kernel ? 64'h0 : FLAG_USER)
                   | (wr ? FLAG_RW : 64'h0)) & (pae_mode ? ~64'h0 : 64'hFFFF_FFFF);

  // sweep counter runs while a clear is in progress, else sits at zero
  always_comb begin
    if ((cmd.init_clr && !sts.init_done) || (cmd.dir_clr && !sts.dclr_done)
        || (cmd.pg_clr && !sts.pclr_done)) begin
      clear_counter_next = clear_counter + 1'b1;
    end else begin
      clear_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_counter <= '0;
    end else begin
      clear_counter <= clear_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_tab <= '{default: '0};
    end else if (cmd.ptr_make) begin
      ptr_tab[d] <= {32'b0, dir_frame} | FLAG_PRESENT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_clr && ({{(32-PW){1'b0}}, clear_counter} < 32'(DIR_DEPTH))) begin
      dir_mem[clear_counter[DW-1:0]] <= '0;
    end else if (cmd.dir_clr) begin
      // only the part of the directory that lies in the store
      if ({21'b0, dclr_w} < 32'(DIR_DEPTH)) begin
        dir_mem[dclr_w[DW-1:0]] <= '0;
      end
    end else if (cmd.dir_make) begin
      dir_mem[tidx] <= {32'b0, tab_frame} | FLAG_RW | FLAG_PRESENT;
    end
    dir_q <= dir_mem[tidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_clr) begin
      pg_mem[clear_counter] <= '0;
    end else if (cmd.pg_clr) begin
      pg_mem[(slot & ~pmask) | (clear_counter & pmask)] <= '0;
    end else if (cmd.pg_write) begin
      pg_mem[slot] <= (req_type == REQ_UNMAP) ? 64'h0 : pg_val;
    end
    pg_q <= pg_mem[slot];
  end

  assign sts.init_done   = (clear_counter == PW'(PAGE_DEPTH - 1));
  assign sts.dclr_done   = (clear_counter[8:0] == 9'h1FF) || (dclr_w == 11'(DIR_DEPTH - 1));
  assign sts.pclr_done   = (clear_counter == pmask);
  assign sts.reserved    = (req_type == REQ_RSVD);
  assign sts.oor         = ({1'b0, virt[31:22]} >= 11'(REGION_COUNT));
  assign sts.lookup      = (req_type == REQ_LOOKUP);
  assign sts.pae         = pae_mode;
  assign sts.ptr_missing = (ptr_tab[d][63:12] == '0);
  assign sts.dir_missing = pae_mode ? (dir_q[63:12] == '0) : (dir_q[31:12] == '0);

  assign hit = pg_q[0] && !sts.dir_missing && (!pae_mode || !sts.ptr_missing);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      found            <= 1'b0;
      phys_frame       <= '0;
      used_dir_frame   <= 1'b0;
      used_table_frame <= 1'b0;
      out_of_range     <= 1'b0;
    end else begin
      if (cmd.set_oor) out_of_range <= 1'b1;
      if (cmd.load_lookup && hit) begin
        found      <= 1'b1;
        phys_frame <= pg_q & (pae_mode ? ~64'hFFF : 64'hFFFF_F000);
      end
      if (cmd.ptr_make) used_dir_frame <= 1'b1;
      if (cmd.dir_make) used_table_frame <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/page_table_map_and_walk_top.sv
// Sequence: lookup, out-of-range and reserved responses pass through the LOOK and EVAL
//   states to OUT; map/unmap into existing tables add a WRITE state; a new table adds
//   page clearing (PAE or standard) and a new PAE directory adds directory clearing.
// Requests: one request at a time; no new request is taken until the response is
//   accepted.
// Reset: synchronous; the block then clears its memories before it takes requests.
`default_nettype none
module page_table_map_and_walk_top #(
  parameter int REGION_COUNT = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_data,
  ptw_req_if.sink  req,
  ptw_rsp_if.source rsp
);
  import ptw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: walk, create, clear, write
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the tables, the captured request and the response registers
  ptw_dp #(
    .REGION_COUNT (REGION_COUNT)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .in_req_type          (req.req_type),
    .in_virt_addr         (req.virt_addr),
    .in_phys_addr         (req.phys_addr),
    .in_kernel_page       (req.kernel_page),
    .in_writeable         (req.writeable),
    .in_spare_dir_frame   (req.spare_dir_frame),
    .in_spare_table_frame (req.spare_table_frame),
    .cmd                  (cmd),
    .sts                  (sts),
    .found                (rsp.found),
    .phys_frame           (rsp.phys_frame),
    .used_dir_frame       (rsp.used_dir_frame),
    .used_table_frame     (rsp.used_table_frame),
    .out_of_range         (rsp.out_of_range)
  );

endmodule
`default_nettype wire

>>> hdl/ptw_chk.sv
`default_nettype none
module ptw_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        found,
  input logic [63:0] phys_frame,
  input logic        used_dir_frame,
  input logic        used_table_frame,
  input logic        out_of_range
);

  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_of_range |-> !found && !used_dir_frame && !used_table_frame)
    else $error("out of range response carries other fields");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> phys_frame == 64'h0)
    else $error("frame nonzero without hit");

  a_dir_table: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && used_dir_frame |-> used_table_frame)
    else $error("new directory without new table");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while response pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(phys_frame))
    else $error("stalled response dropped");

endmodule

bind page_table_map_and_walk_top ptw_chk u_chk (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .found            (rsp.found),
  .phys_frame       (rsp.phys_frame),
  .used_dir_frame   (rsp.used_dir_frame),
  .used_table_frame (rsp.used_table_frame),
  .out_of_range     (rsp.out_of_range)
);
`default_nettype wire

>>> test/tb_page_table_map_and_walk_top.sv
`timescale 1ns / 100ps
module tb_page_table_map_and_walk_top;
  import ptw_pkg::*;

  localparam int REGIONS = 16;
  localparam int DIR_SLOTS = 2 * REGIONS;
  localparam int PAGE_SLOTS = REGIONS * 1024;

  typedef struct {
    req_code_t   kind;
    logic [31:0] va;
    logic [51:0] pa;
    logic        kern;
    logic        wr;
    logic [31:0] dir_frame;
    logic [31:0] tab_frame;
  } page_req_t;

  typedef struct {
    logic        found;
    logic [63:0] frame;
    logic        used_dir;
    logic        used_tab;
    logic        oor;
  } walk_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  ptw_req_if req_bus ();
  ptw_rsp_if rsp_bus ();

  page_table_map_and_walk_top #(.REGION_COUNT(REGIONS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  // Shadow copy of the paging state, kept in step with accepted requests.
  logic        pae_shadow;
  logic [63:0] ptr_shadow [4];
  logic [63:0] dir_shadow [DIR_SLOTS];
  logic [63:0] page_shadow [PAGE_SLOTS];

  page_req_t   pending_reqs [$];
  walk_rsp_t   expected_rsps [$];
  logic [31:0] mapped_vas [$];
  page_req_t   held_req;

  int send_idle_pct;
  int recv_idle_pct;
  int n_pushed;
  int n_accepted;
  int n_checked;
  int n_found;
  int n_tables;
  int n_oor;
  int n_errors;

  // Clock: 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < 30)
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Walk the shadow tables for one request and update them as the block would.
  function automatic walk_rsp_t walk_tables(input page_req_t r);
    walk_rsp_t   res;
    logic [63:0] entry;
    int          d;
    int          tidx;
    int          slot;
    res = '{1'b0, 64'd0, 1'b0, 1'b0, 1'b0};
    if (r.kind == REQ_RSVD)
      return res;
    if ((r.va >> 22) >= REGIONS) begin
      res.oor = 1'b1;
      return res;
    end
    entry = {12'd0, r.pa} | FLAG_PRESENT;
    if (!r.kern) entry |= FLAG_USER;
    if (r.wr) entry |= FLAG_RW;
    if (pae_shadow) begin
      d = r.va >> 30;
      tidx = r.va >> 21;
      slot = tidx * 512 + r.va[20:12];
      if (r.kind == REQ_LOOKUP) begin
        if (ptr_shadow[d][63:12] != 0 && dir_shadow[tidx][63:12] != 0 &&
            page_shadow[slot][0]) begin
          res.found = 1'b1;
          res.frame = {page_shadow[slot][63:12], 12'd0};
        end
      end else begin
        if (ptr_shadow[d][63:12] == 0) begin
          ptr_shadow[d] = {32'd0, r.dir_frame} | FLAG_PRESENT;
          for (int k = 0; k < 512; k++)
            if (d * 512 + k < DIR_SLOTS) dir_shadow[d * 512 + k] = 64'd0;
          res.used_dir = 1'b1;
        end
        if (dir_shadow[tidx][63:12] == 0) begin
          dir_shadow[tidx] = {32'd0, r.tab_frame} | FLAG_RW | FLAG_PRESENT;
          for (int k = 0; k < 512; k++) page_shadow[tidx * 512 + k] = 64'd0;
          res.used_tab = 1'b1;
        end
        page_shadow[slot] = (r.kind == REQ_UNMAP) ? 64'd0 : entry;
      end
    end else begin
      tidx = r.va >> 22;
      slot = tidx * 1024 + r.va[21:12];
      if (r.kind == REQ_LOOKUP) begin
        if (dir_shadow[tidx][31:12] != 0 && page_shadow[slot][0]) begin
          res.found = 1'b1;
          res.frame = {32'd0, page_shadow[slot][31:12], 12'd0};
        end
      end else begin
        if (dir_shadow[tidx][31:12] == 0) begin
          dir_shadow[tidx] = {32'd0, r.tab_frame} | FLAG_RW | FLAG_PRESENT;
          for (int k = 0; k < 1024; k++) page_shadow[tidx * 1024 + k] = 64'd0;
          res.used_tab = 1'b1;
        end
        page_shadow[slot] = (r.kind == REQ_UNMAP) ? 64'd0 : {32'd0, entry[31:0]};
      end
    end
    return res;
  endfunction

  // Driver: predict at acceptance, then present the next pending request.
  initial begin
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_MAP;
    req_bus.virt_addr = '0;
    req_bus.phys_addr = '0;
    req_bus.kernel_page = 1'b0;
    req_bus.writeable = 1'b0;
    req_bus.spare_dir_frame = '0;
    req_bus.spare_table_frame = '0;
    rsp_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        walk_rsp_t want;
        want = walk_tables(held_req);
        if (want.found) n_found++;
        if (want.used_tab) n_tables++;
        if (want.oor) n_oor++;
        expected_rsps.push_back(want);
        n_accepted++;
      end
      // a request on the bus holds until the block takes it
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = pending_reqs.pop_front();
          req_bus.req_type <= held_req.kind;
          req_bus.virt_addr <= held_req.va;
          req_bus.phys_addr <= held_req.pa;
          req_bus.kernel_page <= held_req.kern;
          req_bus.writeable <= held_req.wr;
          req_bus.spare_dir_frame <= held_req.dir_frame;
          req_bus.spare_table_frame <= held_req.tab_frame;
          req_bus.valid <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the response side at random and check each response in order.
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", {63'd0, rsp_bus.found}, 64'd0);
        end else begin
          walk_rsp_t want;
          want = expected_rsps.pop_front();
          n_checked++;
          if (rsp_bus.found !== want.found)
            report_mismatch("found", 64'(rsp_bus.found), 64'(want.found));
          if (rsp_bus.phys_frame !== want.frame)
            report_mismatch("phys_frame", rsp_bus.phys_frame, want.frame);
          if (rsp_bus.used_dir_frame !== want.used_dir)
            report_mismatch("used_dir_frame", 64'(rsp_bus.used_dir_frame),
                            64'(want.used_dir));
          if (rsp_bus.used_table_frame !== want.used_tab)
            report_mismatch("used_table_frame", 64'(rsp_bus.used_table_frame),
                            64'(want.used_tab));
          if (rsp_bus.out_of_range !== want.oor)
            report_mismatch("out_of_range", 64'(rsp_bus.out_of_range), 64'(want.oor));
        end
      end
    end
  end

  function automatic page_req_t make_req(input req_code_t kind, input logic [31:0] va,
                                         input logic [51:0] pa, input logic kern,
                                         input logic wr, input logic [31:0] dframe,
                                         input logic [31:0] tframe);
    page_req_t r;
    r.kind = kind;
    r.va = va;
    r.pa = pa;
    r.kern = kern;
    r.wr = wr;
    r.dir_frame = dframe;
    r.tab_frame = tframe;
    return r;
  endfunction

  task automatic push_req(input page_req_t r);
    pending_reqs.push_back(r);
    n_pushed++;
  endtask

  // Spare frames: mostly real frames, now and then zero or below one page so the
  // new entry still reads as missing.
  function automatic logic [31:0] pick_frame();
    int p;
    p = $urandom_range(99);
    if (p < 2) return 32'd0;
    if (p < 4) return $urandom_range(4095);
    return $urandom;
  endfunction

  // Random requests: most land inside the covered span; lookups favor
  // addresses mapped earlier so that hits are common.
  task automatic push_random(input int count);
    page_req_t   r;
    int          p;
    logic [31:0] va;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      va = ($urandom_range(9) == 0) ? $urandom : ($urandom & 32'h03FF_FFFF);
      r = make_req(REQ_MAP, va, 52'({$urandom, $urandom}), 1'($urandom_range(1)),
                   1'($urandom_range(1)), pick_frame(), pick_frame());
      if (p < 40) begin
        r.kind = REQ_MAP;
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 64) void'(mapped_vas.pop_front());
      end else if (p < 55) begin
        r.kind = REQ_UNMAP;
        if (mapped_vas.size() > 0 && $urandom_range(1))
          r.va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
      end else if (p < 96) begin
        r.kind = REQ_LOOKUP;
        if (mapped_vas.size() > 0 && $urandom_range(3) != 0)
          r.va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
      end else begin
        r.kind = REQ_RSVD;
      end
      push_req(r);
    end
  endtask

  // Block until every queued request is taken and answered, then let the
  // block settle before touching the mode register.
  task automatic drain();
    while (!(n_accepted == n_pushed && expected_rsps.size() == 0)) @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_mode(input logic pae);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= pae;
    pae_shadow = pae;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    pae_shadow = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 49;
    for (int i = 0; i < 4; i++) ptr_shadow[i] = 64'd0;
    for (int i = 0; i < DIR_SLOTS; i++) dir_shadow[i] = 64'd0;
    for (int i = 0; i < PAGE_SLOTS; i++) page_shadow[i] = 64'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Standard two-level mode, directed corners first.
    write_mode(1'b0);
    push_req(make_req(REQ_LOOKUP, 32'h0, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0, {52{1'b1}}, 1'b0, 1'b1, 32'hFFFF_FFFF,
                      32'hFFFF_F000));
    push_req(make_req(REQ_LOOKUP, 32'h0, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0000_1000, '0, 1'b1, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_LOOKUP, 32'h0000_1000, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_UNMAP, 32'h0, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_LOOKUP, 32'h0, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h03FF_FFFF, 52'h5_A5A5_A5A5_A123, 1'b1, 1'b1,
                      32'h1234_5000, 32'hABCD_E000));
    push_req(make_req(REQ_LOOKUP, 32'h03FF_FFFF, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0400_0000, 52'h1000, 1'b0, 1'b1, 32'h1000, 32'h1000));
    push_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_RSVD, 32'h0, 52'h3000, 1'b0, 1'b1, 32'h2000, 32'h2000));
    // zero and sub-page spare frames leave the directory entry looking empty
    push_req(make_req(REQ_MAP, 32'h0040_0000, 52'h7000, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0040_1000, 52'h8000, 1'b0, 1'b1, 32'h0, 32'h0000_0FFF));
    push_req(make_req(REQ_LOOKUP, 32'h0040_1000, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0040_2000, 52'h9001, 1'b1, 1'b0, 32'h0, 32'h0000_1000));
    push_req(make_req(REQ_LOOKUP, 32'h0040_2000, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_random(300);
    drain();

    // PAE three-level mode on the existing tables, then its own corners.
    send_idle_pct = 49;
    recv_idle_pct = 22;
    write_mode(1'b1);
    push_req(make_req(REQ_LOOKUP, 32'h0, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0, {52{1'b1}}, 1'b0, 1'b1, 32'hFFFF_FFFF,
                      32'hFFFF_F000));
    push_req(make_req(REQ_LOOKUP, 32'h0, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h0020_0000, 52'hF_0000_0000_0000, 1'b1, 1'b0,
                      32'h0, 32'h0055_5000));
    push_req(make_req(REQ_LOOKUP, 32'h0020_0000, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_MAP, 32'h03FF_F000, 52'h0_FFFF_FFFF_F000, 1'b0, 1'b0,
                      32'h0, 32'h0077_7000));
    push_req(make_req(REQ_LOOKUP, 32'h03FF_F000, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_req(make_req(REQ_UNMAP, 32'h0420_0000, '0, 1'b0, 1'b0, 32'h0, 32'h0));
    push_random(300);
    drain();

    // Back to standard mode with no idling, then PAE once more.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(1'b0);
    push_random(170);
    drain();
    write_mode(1'b1);
    push_random(150);
    drain();

    $display("checked %0d responses: %0d lookup hits, %0d tables created, %0d out of range",
             n_checked, n_found, n_tables, n_oor);
    $display("covered both paging modes across three idle profiles");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #200000000;
    $display("timeout: %0d of %0d requests answered", n_checked, n_pushed);
    $display("status: fail");
    $finish;
  end

endmodule
